@@ hw/rtl/u8d_pkg.sv @@
`default_nettype none

package u8d_pkg;

  // Field widths of the byte and code point channels.
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;

  // Byte classification masks and patterns.
  localparam logic [ByteW-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [ByteW-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_PAT   = 8'hC0;
  localparam logic [ByteW-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [ByteW-1:0] LEAD3_PAT   = 8'hE0;
  localparam logic [ByteW-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [ByteW-1:0] LEAD4_PAT   = 8'hF0;
  localparam logic [ByteW-1:0] CONT_MASK   = 8'hC0;
  localparam logic [ByteW-1:0] CONT_PAT    = 8'h80;

  // Replacement character for any malformed input.
  localparam logic [CpW-1:0] CP_QMARK = 21'h00003F;

  // Sequence lengths announced by a lead byte.
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Most results one input byte may cause.
  localparam logic [2:0] MAX_RESULTS = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic use_input;   // decode the channel byte rather than the replay queue head
    logic take_input;  // an input transaction is taken this cycle
    logic proc_queue;  // decode the replay queue head
    logic flush;       // close a window left open at the end of the text
    logic final_push;  // hand the held result over as the last one of the byte
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_room;   // output register can take a result this cycle
    logic in_bad;     // the channel byte completes a malformed sequence
    logic q_empty;    // replay queue holds no byte
    logic q_res;      // decoding the queue head gives a result
    logic flush_res;  // the end-of-text flush gives a result
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/u8d_if.sv @@
`default_nettype none

// Byte channel: one byte of UTF-8 text per transaction.
interface u8d_byte_if;
  import u8d_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             text_end;

  modport source (output valid, output data_byte, output text_end, input ready);
  modport sink   (input valid, input data_byte, input text_end, output ready);
endinterface

// Code point channel: one decoded code point per transaction.
interface u8d_cp_if;
  import u8d_pkg::*;

  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           run_last;
  logic           text_done;

  modport source (output valid, output code_point, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input code_point, input run_last, input text_done,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/utf8_to_codepoint_decoder_top.sv @@
`default_nettype none

// A direct result reaches the output register in the cycle after the byte that causes it.
// One byte is taken per cycle while bytes are well formed and results are taken.
// A malformed sequence holds the input while the bytes of the replay queue (up to three)
// are decoded again, the queue is found empty, the flush runs and the last result is handed
// over, as the single decoder is shared between channel and replay queue.
// Reset (asynchronous, active low) closes any open sequence and empties the output register.
module utf8_to_codepoint_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  u8d_byte_if.sink  byte_i,
  u8d_cp_if.source  cp_o
);
  import u8d_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing of input, replay, flush and final hand-over.
  u8d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_ready_o (byte_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Window, replay queue and output register.
  u8d_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_byte_i   (byte_i.data_byte),
    .in_end_i    (byte_i.text_end),
    .out_ready_i (cp_o.ready),
    .out_valid_o (cp_o.valid),
    .out_cp_o    (cp_o.code_point),
    .out_last_o  (cp_o.run_last),
    .out_done_o  (cp_o.text_done),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

@@ hw/rtl/u8d_datapath.sv @@
`default_nettype none

module u8d_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  u8d_pkg::dp_cmd_t          cmd_i,
  input  logic [u8d_pkg::ByteW-1:0] in_byte_i,
  input  logic                      in_end_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [u8d_pkg::CpW-1:0]   out_cp_o,
  output logic                      out_last_o,
  output logic                      out_done_o,
  output u8d_pkg::dp_sts_t          sts_o
);
  import u8d_pkg::*;

  // Sequence window and its bookkeeping.
  logic [ByteW-1:0] win_q [4];
  logic [2:0]       fill_q, fill_nx;
  logic [2:0]       len_q, len_nx;

  // Replay queue of bytes to decode again after a malformed sequence.
  logic [ByteW-1:0] q_q [3];
  logic [ByteW-1:0] rel [3];
  logic [1:0]       qn_q;
  logic [2:0]       wn, rest_n, rel_n;

  // Per-byte bookkeeping: held result, result count, end flag.
  logic [CpW-1:0]   pend_q;
  logic [2:0]       cnt_q;
  logic             end_q;

  // Output register.
  logic             out_valid_q;
  logic [CpW-1:0]   out_cp_q;
  logic             out_last_q;
  logic             out_done_q;

  // Decoder signals.
  logic [ByteW-1:0] src;
  logic [ByteW-1:0] wfull [4];
  logic             step;
  logic             p_emit, p_bad, cont_ok;
  logic [CpW-1:0]   p_cp, asm_cp;
  logic             q_res, flush_res, out_room;
  logic             direct_push, mid_push, push;

  assign src  = cmd_i.use_input ? in_byte_i : q_q[0];
  assign step = cmd_i.take_input | cmd_i.proc_queue;

  // Window as it stands with the new byte placed at the fill position.
  always_comb begin
    wfull = win_q;
    wfull[fill_q[1:0]] = src;
  end

  // Continuation check and code point assembly for a complete window.
  always_comb begin
    cont_ok = ((wfull[1] & CONT_MASK) == CONT_PAT)
           && (len_q < SEQ_LEN3 || ((wfull[2] & CONT_MASK) == CONT_PAT))
           && (len_q < SEQ_LEN4 || ((wfull[3] & CONT_MASK) == CONT_PAT));
    unique case (len_q)
      SEQ_LEN2: asm_cp = {10'd0, wfull[0][4:0], wfull[1][5:0]};
      SEQ_LEN3: asm_cp = {5'd0, wfull[0][3:0], wfull[1][5:0], wfull[2][5:0]};
      default:  asm_cp = {wfull[0][2:0], wfull[1][5:0], wfull[2][5:0], wfull[3][5:0]};
    endcase
  end

  // Decoding of one byte against the window state.
  always_comb begin
    fill_nx = fill_q;
    len_nx  = len_q;
    p_emit  = 1'b0;
    p_bad   = 1'b0;
    p_cp    = CP_QMARK;
    if (fill_q == 3'd0) begin
      priority if (src < ASCII_LIMIT) begin
        p_emit = 1'b1;
        p_cp   = {{(CpW-ByteW){1'b0}}, src};
      end else if ((src & LEAD2_MASK) == LEAD2_PAT) begin
        fill_nx = 3'd1;
        len_nx  = SEQ_LEN2;
      end else if ((src & LEAD3_MASK) == LEAD3_PAT) begin
        fill_nx = 3'd1;
        len_nx  = SEQ_LEN3;
      end else if ((src & LEAD4_MASK) == LEAD4_PAT) begin
        fill_nx = 3'd1;
        len_nx  = SEQ_LEN4;
      end else begin
        p_emit = 1'b1;
      end
    end else begin
      fill_nx = fill_q + 3'd1;
      if (fill_nx == len_q && len_q >= SEQ_LEN2 && len_q <= SEQ_LEN4) begin
        fill_nx = 3'd0;
        len_nx  = 3'd0;
        p_emit  = 1'b1;
        if (cont_ok) begin
          p_cp = asm_cp;
        end else begin
          p_bad = 1'b1;
        end
      end
    end
  end

  // Replay queue reload: the window bytes after the lead, then what is left.
  always_comb begin
    wn     = len_q - 3'd1;
    rest_n = cmd_i.use_input ? 3'd0 : ({1'b0, qn_q} - 3'd1);
    rel_n  = wn + rest_n;
    unique case (len_q)
      SEQ_LEN2: begin
        rel[0] = wfull[1];
        rel[1] = q_q[1];
        rel[2] = q_q[2];
      end
      SEQ_LEN3: begin
        rel[0] = wfull[1];
        rel[1] = wfull[2];
        rel[2] = q_q[1];
      end
      default: begin
        rel[0] = wfull[1];
        rel[1] = wfull[2];
        rel[2] = wfull[3];
      end
    endcase
  end

  // Result bookkeeping and output pushes.
  assign out_room    = !out_valid_q || out_ready_i;
  assign q_res       = p_emit && (cnt_q < MAX_RESULTS);
  assign flush_res   = end_q && (fill_q != 3'd0) && (cnt_q < MAX_RESULTS);
  assign direct_push = cmd_i.take_input && !p_bad
                    && (p_emit || (in_end_i && fill_nx != 3'd0));
  assign mid_push    = (cmd_i.proc_queue && q_res) || (cmd_i.flush && flush_res);
  assign push        = direct_push || mid_push || cmd_i.final_push;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 3'd0;
      len_q       <= 3'd0;
      qn_q        <= 2'd0;
      cnt_q       <= 3'd0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        fill_q <= fill_nx;
        len_q  <= len_nx;
        if (cmd_i.take_input && !p_bad && in_end_i) begin
          fill_q <= 3'd0;
          len_q  <= 3'd0;
        end
      end
      if (cmd_i.flush && end_q) begin
        fill_q <= 3'd0;
        len_q  <= 3'd0;
      end
      if (step && p_bad) begin
        qn_q <= rel_n[1:0];
      end else if (cmd_i.proc_queue) begin
        qn_q <= qn_q - 2'd1;
      end
      if (cmd_i.take_input) begin
        end_q <= in_end_i;
        cnt_q <= p_bad ? 3'd1 : 3'd0;
      end else if (mid_push) begin
        cnt_q <= cnt_q + 3'd1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (step) begin
      win_q[fill_q[1:0]] <= src;
    end
    if (step && p_bad) begin
      q_q <= rel;
    end else if (cmd_i.proc_queue) begin
      q_q[0] <= q_q[1];
      q_q[1] <= q_q[2];
    end
    if (cmd_i.take_input && p_bad) begin
      pend_q <= CP_QMARK;
    end else if (cmd_i.proc_queue && q_res) begin
      pend_q <= p_cp;
    end else if (cmd_i.flush && flush_res) begin
      pend_q <= CP_QMARK;
    end
    if (direct_push) begin
      out_cp_q   <= p_emit ? p_cp : CP_QMARK;
      out_last_q <= 1'b1;
      out_done_q <= in_end_i;
    end else if (mid_push) begin
      out_cp_q   <= pend_q;
      out_last_q <= 1'b0;
      out_done_q <= 1'b0;
    end else if (cmd_i.final_push) begin
      out_cp_q   <= pend_q;
      out_last_q <= 1'b1;
      out_done_q <= end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_cp_o    = out_cp_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

  assign sts_o.out_room  = out_room;
  assign sts_o.in_bad    = p_bad;
  assign sts_o.q_empty   = (qn_q == 2'd0);
  assign sts_o.q_res     = q_res;
  assign sts_o.flush_res = flush_res;

  // An open window always has a legal length and is not yet complete.
  a_window_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 3'd0 |-> (len_q == SEQ_LEN2 || len_q == SEQ_LEN3 || len_q == SEQ_LEN4)
                       && fill_q < len_q)
    else $error("open window with inconsistent length");

  // No more results per byte than the cap.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_RESULTS)
    else $error("result count above cap");

  // A result is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/u8d_ctrl.sv @@
`default_nettype none

module u8d_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  u8d_pkg::dp_sts_t sts_i,
  output u8d_pkg::dp_cmd_t cmd_o
);
  import u8d_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLAY,
    S_FLUSH,
    S_FINAL
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.use_input = (state_q == S_IDLE);
    in_ready_o      = (state_q == S_IDLE) && sts_i.out_room;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.take_input = 1'b1;
          if (sts_i.in_bad) begin
            state_d = S_REPLAY;
          end
        end
      end
      S_REPLAY: begin
        if (sts_i.q_empty) begin
          state_d = S_FLUSH;
        end else if (sts_i.out_room || !sts_i.q_res) begin
          cmd_o.proc_queue = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts_i.out_room || !sts_i.flush_res) begin
          cmd_o.flush = 1'b1;
          state_d     = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts_i.out_room) begin
          cmd_o.final_push = 1'b1;
          state_d          = S_IDLE;
        end
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The final hand-over is only reached through the flush step.
  a_final_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINAL |-> $past(state_q) == S_FLUSH || $past(state_q) == S_FINAL)
    else $error("final step entered out of order");

endmodule

`default_nettype wire
